// ----- sv/hra_pkg.sv -----
// Package for the Householder reflector apply unit: constants, types, helpers.
// No dependencies.
`default_nettype none
package hra_pkg;
  localparam int unsigned MaxRowsDef  = 8;
  localparam int unsigned MaxColsDef  = 8;
  localparam int unsigned FracBitsDef = 16;

  typedef enum logic [1:0] {
    MODE_WR_V = 2'd0,
    MODE_WR_C = 2'd1,
    MODE_APPLY = 2'd2,
    MODE_RD_C = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REG_SIDE = 2'd0,
    REG_ROWS = 2'd1,
    REG_COLS = 2'd2
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TRIMV,
    ST_SCANC,
    ST_W_RD,
    ST_W_ACC,
    ST_W_WR,
    ST_T_RD,
    ST_T_MUL,
    ST_U_RD,
    ST_U_MUL,
    ST_U_WR,
    ST_DONE
  } state_e;

  // saturate a 64-bit signed value to 32 bits, flag in bit 32
  function automatic logic [32:0] sat64(input logic signed [63:0] x);
    logic [32:0] r;
    if (x > 64'sd2147483647) r = {1'b1, 32'h7fffffff};
    else if (x < -64'sd2147483648) r = {1'b1, 32'h80000000};
    else r = {1'b0, x[31:0]};
    return r;
  endfunction
endpackage
`default_nettype wire

// ----- sv/hra_ram.sv -----
// Generic single-port-write, single-read synchronous RAM, registered read.
// No dependencies.
`default_nettype none
module hra_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ----- sv/hra_cmul.sv -----
// Registered complex multiplier with floor rounding after the fraction shift.
// Depends on hra_pkg. The real products are registered; the combine and shift are combinational.
`default_nettype none
module hra_cmul import hra_pkg::*; #(
  parameter int unsigned FracBits = FracBitsDef
) (
  input  wire logic               clk_i,
  input  wire logic signed [31:0] ar_i,
  input  wire logic signed [32:0] ai_i,  // 33 bits to hold a negated imag part
  input  wire logic signed [31:0] br_i,
  input  wire logic signed [31:0] bi_i,
  output logic      signed [63:0] re_o,
  output logic      signed [63:0] im_o
);
  logic signed [64:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [65:0] re_full, im_full;
  always_ff @(posedge clk_i) begin
    p_rr_q <= 65'(ar_i * br_i);
    p_ii_q <= 65'(ai_i * bi_i);
    p_ri_q <= 65'(ar_i * bi_i);
    p_ir_q <= 65'(ai_i * br_i);
  end
  // floor(p/2^F) - floor(q/2^F) - borrow == floor((p-q)/2^F)
  assign re_full = 66'(p_rr_q) - 66'(p_ii_q);
  assign im_full = 66'(p_ri_q) + 66'(p_ir_q);
  assign re_o = 64'(re_full >>> FracBits);
  assign im_o = 64'(im_full >>> FracBits);
endmodule
`default_nettype wire

// ----- sv/hra_ctrl.sv -----
// Sequencer for the apply item: trims v, scans C, forms w, rank-one update.
// Depends on hra_pkg, hra_cmul. Drives the RAM ports of the top level.
`default_nettype none
module hra_ctrl import hra_pkg::*; #(
  parameter int unsigned MaxRows  = MaxRowsDef,
  parameter int unsigned MaxCols  = MaxColsDef,
  parameter int unsigned FracBits = FracBitsDef,
  localparam int unsigned VecLen  = (MaxRows > MaxCols) ? MaxRows : MaxCols,
  localparam int unsigned CAw     = $clog2(MaxRows * MaxCols),
  localparam int unsigned VAw     = (VecLen > 1) ? $clog2(VecLen) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [63:0]      tau_i,
  input  wire logic             left_i,
  input  wire logic [6:0]       m_i,
  input  wire logic [6:0]       n_i,
  // C store
  output logic                  c_we_o,
  output logic [CAw-1:0]        c_waddr_o,
  output logic [63:0]           c_wdata_o,
  output logic [CAw-1:0]        c_raddr_o,
  input  wire logic [63:0]      c_rdata_i,
  // v store read
  output logic [VAw-1:0]        v_raddr_o,
  input  wire logic [63:0]      v_rdata_i,
  // w store
  output logic                  w_we_o,
  output logic [VAw-1:0]        w_waddr_o,
  output logic [63:0]           w_wdata_o,
  output logic [VAw-1:0]        w_raddr_o,
  input  wire logic [63:0]      w_rdata_i,
  output logic                  busy_o,
  output logic                  done_o,
  output logic [6:0]            lastv_o,
  output logic [6:0]            lastc_o,
  output logic                  sat_o
);
  state_e st_q, st_d;
  logic [6:0] lastv_q, lastv_d, lastc_q, lastc_d, i_q, i_d, j_q, j_d;
  logic [1:0] ph_q, ph_d;
  logic sat_q, sat_d;
  logic signed [63:0] acc_re_q, acc_re_d, acc_im_q, acc_im_d;
  logic [63:0] t_q, t_d, cold_q, cold_d, hold_q, hold_d;
  logic signed [31:0] mar, mbr, mbi;
  logic signed [32:0] mai;
  logic signed [63:0] mre, mim;
  logic [32:0] s0, s1;
  logic [6:0] rr, cc;

  hra_cmul #(.FracBits(FracBits)) u_mul (
    .clk_i, .ar_i(mar), .ai_i(mai), .br_i(mbr), .bi_i(mbi), .re_o(mre), .im_o(mim)
  );

  // matrix address from the row/col pair; role of i/j depends on side and phase
  function automatic logic [CAw-1:0] caddr(input logic [6:0] r, input logic [6:0] c);
    return CAw'(r * MaxCols + c);
  endfunction

  // multiplier operands: a (optionally conjugated) times b
  always_comb begin
    mar = '0; mai = '0; mbr = '0; mbi = '0;
    case (st_q)
      ST_W_ACC: begin
        if (left_i) begin  // conj(C)*v
          mar = hold_q[31:0]; mai = -33'(signed'(hold_q[63:32]));
        end else begin
          mar = hold_q[31:0]; mai = 33'(signed'(hold_q[63:32]));
        end
        mbr = v_rdata_i[31:0]; mbi = v_rdata_i[63:32];
      end
      ST_T_MUL: begin  // conj(w or v) * tau
        mar = hold_q[31:0]; mai = -33'(signed'(hold_q[63:32]));
        mbr = tau_i[31:0]; mbi = tau_i[63:32];
      end
      ST_U_MUL: begin  // (v or w) * t
        mar = hold_q[31:0]; mai = 33'(signed'(hold_q[63:32]));
        mbr = t_q[31:0]; mbi = t_q[63:32];
      end
      default: ;
    endcase
  end

  // i walks rows of C, j columns, in every phase
  assign rr = i_q;
  assign cc = j_q;

  always_comb begin
    st_d = st_q; lastv_d = lastv_q; lastc_d = lastc_q; i_d = i_q; j_d = j_q;
    ph_d = ph_q; sat_d = sat_q; acc_re_d = acc_re_q; acc_im_d = acc_im_q;
    t_d = t_q; cold_d = cold_q; hold_d = hold_q;
    s0 = '0; s1 = '0;
    case (st_q)
      ST_IDLE: if (start_i) begin
        lastv_d = left_i ? m_i : n_i; lastc_d = '0; sat_d = 1'b0; ph_d = '0;
        st_d = ST_TRIMV;
      end
      ST_TRIMV: begin  // ph 0: issue read of v[lastv-1]; ph 1: test it
        if (ph_q == 2'd0) begin
          if (lastv_q == '0) st_d = ST_DONE; else ph_d = 2'd1;
        end else begin
          ph_d = 2'd0;
          if (v_rdata_i == '0) lastv_d = lastv_q - 7'd1;
          else begin
            st_d = ST_SCANC;
            if (left_i) begin j_d = n_i; i_d = '0; end
            else begin i_d = m_i; j_d = '0; end
          end
        end
      end
      ST_SCANC: begin
        // outer index counts down from the extent, inner walks 0..lastv-1
        if (ph_q == 2'd0) begin
          if ((left_i ? j_q : i_q) == '0) begin
            st_d = (lastc_q == '0) ? ST_DONE : ST_W_RD;
            i_d = '0; j_d = '0; ph_d = '0;
          end else ph_d = 2'd1;
        end else begin
          ph_d = 2'd0;
          if (c_rdata_i != '0) begin
            lastc_d = left_i ? j_q : i_q;
            i_d = '0; j_d = '0; st_d = ST_W_RD;
            acc_re_d = '0; acc_im_d = '0;
          end else if (left_i) begin
            if (i_q + 7'd1 == lastv_q) begin i_d = '0; j_d = j_q - 7'd1; end
            else i_d = i_q + 7'd1;
          end else begin
            if (j_q + 7'd1 == lastv_q) begin j_d = '0; i_d = i_q - 7'd1; end
            else j_d = j_q + 7'd1;
          end
        end
        acc_re_d = '0; acc_im_d = '0;
      end
      // w pass: outer index k over lastc, inner over lastv.
      // left: C(i,j) with j=outer; right: C(i,j) with i=outer, i.e. row=outer.
      ST_W_RD: begin
        if (ph_q == 2'd0) ph_d = 2'd1;
        else begin hold_d = c_rdata_i; ph_d = 2'd0; st_d = ST_W_ACC; end
      end
      ST_W_ACC: begin
        if (ph_q == 2'd0) ph_d = 2'd1;
        else begin
          ph_d = 2'd0;
          acc_re_d = acc_re_q + mre; acc_im_d = acc_im_q + mim;
          if ((left_i ? i_q : j_q) + 7'd1 == lastv_q) st_d = ST_W_WR;
          else begin
            if (left_i) i_d = i_q + 7'd1; else j_d = j_q + 7'd1;
            st_d = ST_W_RD;
          end
        end
      end
      ST_W_WR: begin
        s0 = sat64(acc_re_q); s1 = sat64(acc_im_q);
        sat_d = sat_q | s0[32] | s1[32];
        acc_re_d = '0; acc_im_d = '0;
        if (left_i) begin
          i_d = '0;
          if (j_q + 7'd1 == lastc_q) begin j_d = '0; st_d = ST_T_RD; end
          else begin j_d = j_q + 7'd1; st_d = ST_W_RD; end
        end else begin
          j_d = '0;
          if (i_q + 7'd1 == lastc_q) begin i_d = '0; st_d = ST_T_RD; end
          else begin i_d = i_q + 7'd1; st_d = ST_W_RD; end
        end
      end
      // t for outer column j: conj(w_j) (left) or conj(v_j) (right), times tau
      ST_T_RD: begin
        if (ph_q == 2'd0) ph_d = 2'd1;
        else begin
          ph_d = 2'd0; st_d = ST_T_MUL;
          hold_d = left_i ? w_rdata_i : v_rdata_i;
        end
      end
      ST_T_MUL: begin
        if (ph_q == 2'd0) ph_d = 2'd1;
        else begin
          ph_d = 2'd0;
          s0 = sat64(mre); s1 = sat64(mim);
          sat_d = sat_q | s0[32] | s1[32];
          t_d = {s1[31:0], s0[31:0]};
          i_d = '0; st_d = ST_U_RD;
        end
      end
      ST_U_RD: begin  // read C(i,j) and the row factor (v_i left, w_i right)
        if (ph_q == 2'd0) ph_d = 2'd1;
        else begin
          ph_d = 2'd0; cold_d = c_rdata_i;
          hold_d = left_i ? v_rdata_i : w_rdata_i; st_d = ST_U_MUL;
        end
      end
      ST_U_MUL: begin
        if (ph_q == 2'd0) ph_d = 2'd1;
        else begin
          ph_d = 2'd0;
          acc_re_d = 64'(signed'(cold_q[31:0])) - mre;
          acc_im_d = 64'(signed'(cold_q[63:32])) - mim;
          st_d = ST_U_WR;
        end
      end
      ST_U_WR: begin
        s0 = sat64(acc_re_q); s1 = sat64(acc_im_q);
        sat_d = sat_q | s0[32] | s1[32];
        if (i_q + 7'd1 == (left_i ? lastv_q : lastc_q)) begin
          i_d = '0;
          if (j_q + 7'd1 == (left_i ? lastc_q : lastv_q)) st_d = ST_DONE;
          else begin j_d = j_q + 7'd1; st_d = ST_T_RD; end
        end else begin
          i_d = i_q + 7'd1; st_d = ST_U_RD;
        end
      end
      ST_DONE: st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  // memory port outputs
  always_comb begin
    c_raddr_o = caddr(rr, cc);
    v_raddr_o = VAw'(left_i ? i_q : j_q);
    w_raddr_o = VAw'(left_i ? j_q : i_q);
    if (st_q == ST_TRIMV) v_raddr_o = VAw'(lastv_q - 7'd1);
    if (st_q == ST_SCANC) begin
      c_raddr_o = left_i ? caddr(i_q, j_q - 7'd1) : caddr(i_q - 7'd1, j_q);
    end
    if (st_q == ST_W_RD || st_q == ST_W_ACC) begin
      c_raddr_o = left_i ? caddr(i_q, j_q) : caddr(i_q, j_q);
      v_raddr_o = VAw'(left_i ? i_q : j_q);
    end
    if (st_q == ST_T_RD) begin
      w_raddr_o = VAw'(j_q);
      v_raddr_o = VAw'(j_q);
    end
    if (st_q == ST_U_RD) begin
      v_raddr_o = VAw'(i_q);
      w_raddr_o = VAw'(i_q);
    end
    c_we_o = (st_q == ST_U_WR);
    c_waddr_o = caddr(i_q, j_q);
    c_wdata_o = {s1[31:0], s0[31:0]};
    w_we_o = (st_q == ST_W_WR);
    w_waddr_o = VAw'(left_i ? j_q : i_q);
    w_wdata_o = {s1[31:0], s0[31:0]};
  end

  assign busy_o  = (st_q != ST_IDLE);
  assign done_o  = (st_q == ST_DONE);
  assign lastv_o = lastv_q;
  assign lastc_o = lastc_q;
  assign sat_o   = sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; ph_q <= '0; lastv_q <= '0; lastc_q <= '0;
      i_q <= '0; j_q <= '0; sat_q <= 1'b0;
    end else begin
      st_q <= st_d; ph_q <= ph_d; lastv_q <= lastv_d; lastc_q <= lastc_d;
      i_q <= i_d; j_q <= j_d; sat_q <= sat_d;
    end
  end
  always_ff @(posedge clk_i) begin
    acc_re_q <= acc_re_d; acc_im_q <= acc_im_d;
    t_q <= t_d; cold_q <= cold_d; hold_q <= hold_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) c_we_o |-> !w_we_o)
    else $error("C and w written together");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !busy_o)
    else $error("done did not return to idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_W_RD) |-> (lastv_q != '0 && lastc_q != '0))
    else $error("w pass with empty extent");
endmodule
`default_nettype wire

// ----- sv/householder_reflector_apply_unit.sv -----
// Top level of the Householder reflector apply unit.
// Depends on hra_pkg, hra_ram, hra_ctrl.
// Loads of v and C elements are written into their RAMs when accepted; a read
// of C passes the registered RAM read and then the result register before it
// is on the output. An apply item is walked by a sequencer around one shared
// complex multiplier and the C, v and w RAMs: it tests v entries in the trim,
// scans C elements, forms the products of the w pass and writes each w entry,
// forms each t factor and updates each element of C.
// Inputs are taken only while no apply or read is in flight and the result
// register is free.
`default_nettype none
module householder_reflector_apply_unit import hra_pkg::*; #(
  parameter int unsigned MaxRows  = MaxRowsDef,
  parameter int unsigned MaxCols  = MaxColsDef,
  parameter int unsigned FracBits = FracBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [3:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [2:0]  row_index_i,
  input  wire logic [2:0]  col_index_i,
  input  wire logic signed [31:0] value_re_i,
  input  wire logic signed [31:0] value_im_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             result_kind_o,
  output logic signed [31:0] data_re_o,
  output logic signed [31:0] data_im_o,
  output logic [3:0]       active_v_length_o,
  output logic [3:0]       active_c_extent_o,
  output logic             saturated_o
);
  localparam int unsigned VecLen = (MaxRows > MaxCols) ? MaxRows : MaxCols;
  localparam int unsigned CAw = $clog2(MaxRows * MaxCols);
  localparam int unsigned VAw = (VecLen > 1) ? $clog2(VecLen) : 1;

  logic side_q, rd_pend_q, rd_ok_q, ov_q, kind_q, sat_res_q;
  logic [3:0] rows_q, cols_q, lv_q, lc_q;
  logic [63:0] dat_q, tau_q;
  logic acc, busy, done, rd_ok;
  logic [6:0] m_eff, n_eff, lastv, lastc;
  logic cwe, cwe_c, wwe, csat;
  logic [CAw-1:0] cwa, cra, cwa_c, cra_c;
  logic [63:0] cwd, cwd_c, crd, vrd, wwd, wrd;
  logic [VAw-1:0] vra, vra_c, wwa, wra;
  logic vwe;

  assign in_ready_o = !busy && !rd_pend_q && !ov_q;
  assign acc = in_valid_i && in_ready_o;
  assign m_eff = (32'(rows_q) > MaxRows) ? 7'(MaxRows) : 7'(rows_q);
  assign n_eff = (32'(cols_q) > MaxCols) ? 7'(MaxCols) : 7'(cols_q);
  assign rd_ok = (32'(row_index_i) < MaxRows) && (32'(col_index_i) < MaxCols);

  always_comb begin
    cwe = cwe_c; cwa = cwa_c; cwd = cwd_c; cra = cra_c; vra = vra_c;
    if (!busy) begin
      cwe = acc && mode_i == MODE_WR_C && rd_ok;
      cwa = CAw'(32'(row_index_i) * MaxCols + 32'(col_index_i));
      cwd = {value_im_i, value_re_i};
      cra = cwa;
    end
  end
  assign vwe = acc && mode_i == MODE_WR_V && (32'(row_index_i) < VecLen);

  hra_ram #(.Width(64), .Depth(MaxRows * MaxCols)) u_cram (
    .clk_i, .we_i(cwe), .waddr_i(cwa), .wdata_i(cwd), .raddr_i(cra), .rdata_o(crd));
  hra_ram #(.Width(64), .Depth(VecLen)) u_vram (
    .clk_i, .we_i(vwe), .waddr_i(VAw'(row_index_i)), .wdata_i(cwd),
    .raddr_i(vra), .rdata_o(vrd));
  hra_ram #(.Width(64), .Depth(VecLen)) u_wram (
    .clk_i, .we_i(wwe), .waddr_i(wwa), .wdata_i(wwd), .raddr_i(wra), .rdata_o(wrd));

  hra_ctrl #(.MaxRows(MaxRows), .MaxCols(MaxCols), .FracBits(FracBits)) u_ctrl (
    .clk_i, .rst_ni,
    .start_i(acc && mode_i == MODE_APPLY && {value_im_i, value_re_i} != '0),
    .tau_i(tau_q), .left_i(!side_q), .m_i(m_eff), .n_i(n_eff),
    .c_we_o(cwe_c), .c_waddr_o(cwa_c), .c_wdata_o(cwd_c), .c_raddr_o(cra_c),
    .c_rdata_i(crd), .v_raddr_o(vra_c), .v_rdata_i(vrd),
    .w_we_o(wwe), .w_waddr_o(wwa), .w_wdata_o(wwd), .w_raddr_o(wra),
    .w_rdata_i(wrd), .busy_o(busy), .done_o(done),
    .lastv_o(lastv), .lastc_o(lastc), .sat_o(csat));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= 1'b0; rows_q <= 4'd8; cols_q <= 4'd8;
      rd_pend_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_SIDE: side_q <= cfg_data_i[0];
          REG_ROWS: rows_q <= cfg_data_i;
          REG_COLS: cols_q <= cfg_data_i;
          default: ;
        endcase
      end
      rd_pend_q <= acc && mode_i == MODE_RD_C;
      if (out_valid_o && out_ready_i) ov_q <= 1'b0;
      if (rd_pend_q || done || (acc && mode_i == MODE_APPLY
          && {value_im_i, value_re_i} == '0)) ov_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin tau_q <= {value_im_i, value_re_i}; rd_ok_q <= rd_ok; end
    if (rd_pend_q) begin
      kind_q <= 1'b0; dat_q <= rd_ok_q ? crd : '0;
      lv_q <= '0; lc_q <= '0; sat_res_q <= 1'b0;
    end else if (done) begin
      kind_q <= 1'b1; dat_q <= '0; lv_q <= 4'(lastv); lc_q <= 4'(lastc);
      sat_res_q <= csat;
    end else if (acc && mode_i == MODE_APPLY) begin
      kind_q <= 1'b1; dat_q <= '0; lv_q <= '0; lc_q <= '0; sat_res_q <= 1'b0;
    end
  end

  assign out_valid_o = ov_q;
  assign result_kind_o = kind_q;
  assign data_re_o = dat_q[31:0];
  assign data_im_o = dat_q[63:32];
  assign active_v_length_o = lv_q;
  assign active_c_extent_o = lc_q;
  assign saturated_o = sat_res_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) in_ready_o |-> !busy)
    else $error("input taken during apply");
  assert property (@(posedge clk_i) disable iff (!rst_ni) rd_pend_q |-> !ov_q)
    else $error("result register overrun");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !result_kind_o) |-> (saturated_o == 1'b0))
    else $error("read result with flag");
endmodule
`default_nettype wire
